/* sv/fmcc_pkg.sv */
// Shared types, constants and CRC helper functions of the framed message CRC checker.
package fmcc_pkg;

  // Frame layout.
  localparam logic [7:0] START_MARK = 8'h7E;
  localparam logic [7:0] END_MARK   = 8'hE7;
  localparam logic [7:0] KIND_SYNC  = 8'h10;
  localparam logic [7:0] KIND_SLEEP = 8'h0A;
  localparam int SYNC_LEN      = 12;
  localparam int SLEEP_LEN     = 24;
  localparam int SYNC_PAYLOAD  = 7;
  localparam int SLEEP_PAYLOAD = 19;

  // Payload store: two banks of the longest payload.
  localparam int PAYLOAD_MAX = 19;
  localparam int MEM_DEPTH   = 2 * PAYLOAD_MAX;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);
  localparam int IDX_W       = 5;

  // CRC register reset values (CRC-16/MODBUS).
  localparam logic [15:0] CRC_POLY_RST   = 16'h8005;
  localparam logic [15:0] CRC_INIT_RST   = 16'hFFFF;
  localparam logic [15:0] CRC_XOROUT_RST = 16'h0000;
  localparam logic        REFLECT_IN_RST  = 1'b1;
  localparam logic        REFLECT_OUT_RST = 1'b1;

  typedef enum logic [2:0] {
    CFG_CRC_POLY    = 3'd0,
    CFG_CRC_INIT    = 3'd1,
    CFG_CRC_XOROUT  = 3'd2,
    CFG_REFLECT_IN  = 3'd3,
    CFG_REFLECT_OUT = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_REJECT = 2'd0,
    ST_SYNC   = 2'd1,
    ST_SLEEP  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CAUSE_NONE       = 3'd0,
    CAUSE_BAD_START  = 3'd1,
    CAUSE_BAD_TYPE   = 3'd2,
    CAUSE_BAD_LENGTH = 3'd3,
    CAUSE_BAD_END    = 3'd4,
    CAUSE_CRC        = 3'd5
  } cause_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_beat_t;

  typedef struct packed {
    status_t          status;
    cause_t           reject_cause;
    logic             nack_due;
    logic [7:0]       frame_kind;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] payload_index;
    logic             run_last;
  } out_beat_t;

  // Verdict of one finished frame, waiting for or driving the output run.
  typedef struct packed {
    status_t          status;
    cause_t           cause;
    logic             nack;
    logic [7:0]       kind;
    logic [IDX_W-1:0] last_idx;
    logic             bank;
    logic             accept;
  } run_desc_t;

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [15:0] flip16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[15-i] = v[i];
    end
    return r;
  endfunction

  // One byte through the CRC register, MSB first, eight shift and XOR steps.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b,
                                             input logic [15:0] poly, input logic refl);
    logic [15:0] c;
    logic [7:0]  d;
    d = refl ? flip8(b) : b;
    c = crc ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* sv/framed_message_crc_checker.sv */
// Framed message checker with configurable CRC-16 and a banked payload store.
//
//   channel  | ports                            | beat
//   ---------+----------------------------------+---------------------------------------
//   input    | in_valid, in_stall, in_beat      | one frame byte, frame_end on the last
//   output   | out_valid, out_stall, out_beat   | one payload byte, or one reject verdict
//   config   | cfg_we, cfg_index, cfg_wdata     | one CRC register write, no read-back
//
// The input side takes one byte every cycle unless in_stall is high; the CRC update of a
// payload byte is done in the cycle the byte is taken. The output side gives one beat every
// cycle unless out_stall holds it: seven or nineteen beats for an accepted frame, one for a
// rejected one. Results pass the verdict registers, the memory read and the output register.
// The payload store holds two banks, so the next frame fills one bank while the previous
// run is read from the other. One finished verdict may wait behind a running output run;
// while it waits, in_stall is high. With a steady sink this stall only appears when frames
// are shorter than the run of the frame before them.
// Reset (rst_n low, synchronous) empties the pipeline, clears the frame state and loads the
// MODBUS CRC settings. The payload store is not cleared: only entries written by the
// current frame are ever read.
// out_stall holds the output register; the read stage behind it holds too, and the run
// issuer stops, so no beat is dropped.
module framed_message_crc_checker
  import fmcc_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // Frame byte input.
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_beat,
  // Result output.
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_beat
);

  // The byte counter must hold the saturation value itself.
  localparam int CntW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CntW-1:0] CntMax      = CntW'(MAX_FRAME_BYTES);
  localparam logic [CntW-1:0] SyncPayEnd  = CntW'(2 + SYNC_PAYLOAD);
  localparam logic [CntW-1:0] SleepPayEnd = CntW'(2 + SLEEP_PAYLOAD);
  localparam logic [CntW-1:0] SyncCrcEnd  = CntW'(4 + SYNC_PAYLOAD);
  localparam logic [CntW-1:0] SleepCrcEnd = CntW'(4 + SLEEP_PAYLOAD);
  localparam logic [CntW-1:0] SyncLen     = CntW'(SYNC_LEN);
  localparam logic [CntW-1:0] SleepLen    = CntW'(SLEEP_LEN);
  localparam logic [IDX_W-1:0] SyncLast   = IDX_W'(SYNC_PAYLOAD - 1);
  localparam logic [IDX_W-1:0] SleepLast  = IDX_W'(SLEEP_PAYLOAD - 1);
  localparam logic [IDX_W-1:0] IdxMax     = IDX_W'(PAYLOAD_MAX - 1);

  // Configuration registers.
  logic [15:0] crc_poly_r, crc_init_r, crc_xorout_r;
  logic        reflect_in_r, reflect_out_r;

  // Frame state.
  logic [CntW-1:0] cnt_r, cnt_upd, cnt_nxt;
  logic            start_ok_r, start_ok_upd, start_ok_nxt;
  logic [7:0]      kind_r, kind_upd, kind_nxt;
  logic [15:0]     crc_r, crc_upd, crc_nxt;
  logic [15:0]     crc_rx_r, crc_rx_upd, crc_rx_nxt;
  logic            end_ok_r, end_ok_upd, end_ok_nxt;
  logic            wr_bank_r, wr_bank_nxt;

  // Payload store and its ports.
  logic [7:0]        payload_mem_r [MEM_DEPTH];
  logic [7:0]        rd_data_r;
  logic              mem_we, rd_en;
  logic [MEM_AW-1:0] wr_addr, rd_addr;
  logic [CntW-1:0]   p_off;
  logic [IDX_W-1:0]  wr_idx;

  // Run control and output pipeline.
  run_desc_t        desc, pend_r, cur_r;
  logic             pend_valid_r, cur_valid_r, s1_valid_r, s1_acc_r, out_valid_r;
  logic [IDX_W-1:0] idx_r;
  out_beat_t        s1_r, out_r, out_nxt;
  logic             in_fire, frame_done, pend_take, issue, cur_done, s1_take, out_load;

  // Decode helpers.
  logic            kind_known, upd_known;
  logic [CntW-1:0] pay_end, crc_end, end_pos, flen_upd;
  logic [15:0]     crc_final;

  // --------------------------------------------------------------------------
  // Configuration writes; the user makes them only while the block is idle, unchecked here.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r    <= CRC_POLY_RST;
      crc_init_r    <= CRC_INIT_RST;
      crc_xorout_r  <= CRC_XOROUT_RST;
      reflect_in_r  <= REFLECT_IN_RST;
      reflect_out_r <= REFLECT_OUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CRC_POLY:    crc_poly_r    <= cfg_wdata;
        CFG_CRC_INIT:    crc_init_r    <= cfg_wdata;
        CFG_CRC_XOROUT:  crc_xorout_r  <= cfg_wdata;
        CFG_REFLECT_IN:  reflect_in_r  <= cfg_wdata[0];
        CFG_REFLECT_OUT: reflect_out_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Frame byte parsing. The layout positions depend on the type byte seen so far.
  // --------------------------------------------------------------------------
  assign in_fire    = in_valid && !in_stall;
  assign frame_done = in_fire && in_beat.frame_end;

  assign kind_known = (kind_r == KIND_SYNC) || (kind_r == KIND_SLEEP);
  assign pay_end    = (kind_r == KIND_SYNC) ? SyncPayEnd : SleepPayEnd;
  assign crc_end    = (kind_r == KIND_SYNC) ? SyncCrcEnd : SleepCrcEnd;
  assign end_pos    = ((kind_r == KIND_SYNC) ? SyncLen : SleepLen) - CntW'(1);

  assign p_off   = cnt_r - CntW'(2);
  assign wr_idx  = p_off[IDX_W-1:0];
  assign wr_addr = wr_bank_r ? (MEM_AW'(wr_idx) + MEM_AW'(PAYLOAD_MAX)) : MEM_AW'(wr_idx);

  always_comb begin
    start_ok_upd = start_ok_r;
    kind_upd     = kind_r;
    crc_upd      = crc_r;
    crc_rx_upd   = crc_rx_r;
    end_ok_upd   = end_ok_r;
    mem_we       = 1'b0;
    priority if (cnt_r == '0) begin
      start_ok_upd = (in_beat.rx_byte == START_MARK);
      crc_upd      = crc_init_r;
      crc_rx_upd   = '0;
      end_ok_upd   = 1'b0;
      kind_upd     = '0;
    end else if (cnt_r == CntW'(1)) begin
      kind_upd = in_beat.rx_byte;
    end else if (kind_known && cnt_r < pay_end) begin
      mem_we  = in_fire;
      crc_upd = crc16_feed(crc_r, in_beat.rx_byte, crc_poly_r, reflect_in_r);
    end else if (kind_known && cnt_r < crc_end) begin
      crc_rx_upd = {crc_rx_r[7:0], in_beat.rx_byte};
    end else if (kind_known && cnt_r == end_pos) begin
      end_ok_upd = (in_beat.rx_byte == END_MARK);
    end else begin
      end_ok_upd = end_ok_r;
    end
    cnt_upd = (cnt_r < CntMax) ? cnt_r + CntW'(1) : cnt_r;
  end

  // A finished frame returns the parser to its reset state and switches the write bank.
  always_comb begin
    cnt_nxt      = cnt_r;
    start_ok_nxt = start_ok_r;
    kind_nxt     = kind_r;
    crc_nxt      = crc_r;
    crc_rx_nxt   = crc_rx_r;
    end_ok_nxt   = end_ok_r;
    wr_bank_nxt  = wr_bank_r;
    if (frame_done) begin
      cnt_nxt      = '0;
      start_ok_nxt = 1'b0;
      kind_nxt     = '0;
      crc_nxt      = '0;
      crc_rx_nxt   = '0;
      end_ok_nxt   = 1'b0;
      wr_bank_nxt  = !wr_bank_r;
    end else if (in_fire) begin
      cnt_nxt      = cnt_upd;
      start_ok_nxt = start_ok_upd;
      kind_nxt     = kind_upd;
      crc_nxt      = crc_upd;
      crc_rx_nxt   = crc_rx_upd;
      end_ok_nxt   = end_ok_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      start_ok_r <= 1'b0;
      kind_r     <= '0;
      crc_r      <= '0;
      crc_rx_r   <= '0;
      end_ok_r   <= 1'b0;
      wr_bank_r  <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      start_ok_r <= start_ok_nxt;
      kind_r     <= kind_nxt;
      crc_r      <= crc_nxt;
      crc_rx_r   <= crc_rx_nxt;
      end_ok_r   <= end_ok_nxt;
      wr_bank_r  <= wr_bank_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Verdict on the closing byte. The closing byte of a frame that reaches the CRC
  // check is the end mark, which leaves both CRC registers alone, so the registered
  // values are compared directly.
  // --------------------------------------------------------------------------
  assign upd_known = (kind_upd == KIND_SYNC) || (kind_upd == KIND_SLEEP);
  assign flen_upd  = (kind_upd == KIND_SYNC) ? SyncLen : SleepLen;
  assign crc_final = (reflect_out_r ? flip16(crc_r) : crc_r) ^ crc_xorout_r;

  always_comb begin
    desc.status   = ST_REJECT;
    desc.cause    = CAUSE_NONE;
    desc.nack     = 1'b0;
    desc.kind     = kind_upd;
    desc.last_idx = '0;
    desc.bank     = wr_bank_r;
    desc.accept   = 1'b0;
    priority if (!start_ok_upd) begin
      desc.cause = CAUSE_BAD_START;
    end else if (!upd_known) begin
      desc.cause = CAUSE_BAD_TYPE;
    end else if (cnt_upd != flen_upd) begin
      desc.cause = CAUSE_BAD_LENGTH;
      desc.nack  = 1'b1;
    end else if (!end_ok_upd) begin
      desc.cause = CAUSE_BAD_END;
      desc.nack  = 1'b1;
    end else if (crc_final != crc_rx_r) begin
      desc.cause = CAUSE_CRC;
      desc.nack  = 1'b1;
    end else begin
      desc.accept   = 1'b1;
      desc.status   = (kind_upd == KIND_SYNC) ? ST_SYNC : ST_SLEEP;
      desc.last_idx = (kind_upd == KIND_SYNC) ? SyncLast : SleepLast;
    end
  end

  // --------------------------------------------------------------------------
  // Run control: one waiting verdict, one running verdict, one beat a cycle unless stalled.
  // --------------------------------------------------------------------------
  assign out_load  = s1_valid_r && (!out_valid_r || !out_stall);
  assign s1_take   = !s1_valid_r || out_load;
  assign issue     = cur_valid_r && s1_take;
  assign cur_done  = issue && (idx_r == cur_r.last_idx);
  assign pend_take = pend_valid_r && (!cur_valid_r || cur_done);
  assign in_stall  = pend_valid_r && !pend_take;

  assign rd_en   = issue && cur_r.accept;
  assign rd_addr = cur_r.bank ? (MEM_AW'(idx_r) + MEM_AW'(PAYLOAD_MAX)) : MEM_AW'(idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      cur_valid_r  <= 1'b0;
      idx_r        <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (frame_done) begin
        pend_valid_r <= 1'b1;
      end else if (pend_take) begin
        pend_valid_r <= 1'b0;
      end

      if (pend_take) begin
        cur_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (cur_done) begin
        cur_valid_r <= 1'b0;
      end else if (issue) begin
        idx_r <= idx_r + IDX_W'(1);
      end

      if (issue) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The read data joins the beat on its way into the output register.
  always_comb begin
    out_nxt              = s1_r;
    out_nxt.payload_byte = s1_acc_r ? rd_data_r : 8'h00;
  end

  // Payload side of the run control.
  always_ff @(posedge clk) begin
    if (frame_done) begin
      pend_r <= desc;
    end
    if (pend_take) begin
      cur_r <= pend_r;
    end
    if (issue) begin
      s1_r.status        <= cur_r.status;
      s1_r.reject_cause  <= cur_r.cause;
      s1_r.nack_due      <= cur_r.nack;
      s1_r.frame_kind    <= cur_r.kind;
      s1_r.payload_byte  <= '0;
      s1_r.payload_index <= idx_r;
      s1_r.run_last      <= cur_done;
      s1_acc_r           <= cur_r.accept;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  // Payload store: one write port from the parser, one registered read port for the run.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      payload_mem_r[wr_addr] <= in_beat.rx_byte;
    end
    if (rd_en) begin
      rd_data_r <= payload_mem_r[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // The parser never writes the bank that an accepted run is reading.
  a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && cur_valid_r && cur_r.accept) |-> (wr_bank_r != cur_r.bank))
    else $error("payload write into the bank being read");

  // Within a run, beats follow without gaps and count up by one.
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !out_r.run_last) |=>
      (out_valid_r && out_r.payload_index == $past(out_r.payload_index) + IDX_W'(1)))
    else $error("gap or skip inside a payload run");

  // A reject verdict is a single beat with an empty payload.
  a_reject_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_REJECT) |->
      (out_r.run_last && out_r.payload_byte == 8'h00 && out_r.payload_index == '0))
    else $error("malformed reject beat");

  // The read stage never points past the longest payload.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (s1_r.payload_index <= IdxMax))
    else $error("payload index out of range");

endmodule

/* bench/framed_message_crc_checker_tb.sv */
// Self-checking bench for the framed message CRC checker, with directed and random frames.
`timescale 1ns / 100ps

module framed_message_crc_checker_tb
  import fmcc_pkg::*;
();

  // The byte counter of the block saturates at this value.
  localparam int MAX_FRAME  = 32;
  // The run is stopped as failed after this many clock cycles.
  localparam int CYCLE_CAP  = 400000;
  // Only this many mismatches are printed in full. Any beyond it are only counted.
  localparam int REPORT_CAP = 10;
  // Cycles allowed after the last result.
  localparam int SETTLE     = 8;

  // Shapes of generated frames. Well-formed frames are the majority. Most of the other
  // shapes break one rule of the framing; FORM_NOISE is random bytes.
  typedef enum int {
    FORM_GOOD,
    FORM_BAD_CRC,
    FORM_BAD_END,
    FORM_BAD_START,
    FORM_BAD_TYPE,
    FORM_SHORT,
    FORM_LONG,
    FORM_NOISE
  } frame_form_t;

  // Frame predictor and the queue of result beats that it still waits for.
  // The predictor holds its own copy of the CRC settings and of the frame state.
  class frame_verdict_tracker;
    logic [15:0] poly;
    logic [15:0] seed_val;
    logic [15:0] xorout;
    logic        refl_in;
    logic        refl_out;
    int unsigned count_cap;
    int unsigned byte_count;
    logic        start_ok;
    logic        end_ok;
    logic [7:0]  kind;
    logic [15:0] crc_run;
    logic [15:0] crc_rx;
    logic [7:0]  payload [PAYLOAD_MAX];
    out_beat_t   awaited_beats [$];
    int unsigned mismatches;

    function new(int unsigned cap);
      count_cap  = cap;
      mismatches = 0;
      poly       = CRC_POLY_RST;
      seed_val   = CRC_INIT_RST;
      xorout     = CRC_XOROUT_RST;
      refl_in    = REFLECT_IN_RST;
      refl_out   = REFLECT_OUT_RST;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_count = 0;
      start_ok   = 1'b0;
      end_ok     = 1'b0;
      kind       = '0;
      crc_run    = '0;
      crc_rx     = '0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] v);
      case (idx)
        CFG_CRC_POLY:    poly     = v;
        CFG_CRC_INIT:    seed_val = v;
        CFG_CRC_XOROUT:  xorout   = v;
        CFG_REFLECT_IN:  refl_in  = v[0];
        CFG_REFLECT_OUT: refl_out = v[0];
        default: ;
      endcase
    endfunction

    // Reverses the order of the low 'width' bits.
    function logic [15:0] mirror(logic [15:0] v, int width);
      logic [15:0] r;
      r = '0;
      for (int i = 0; i < width; i++) r[width-1-i] = v[i];
      return r;
    endfunction

    function logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
      logic [15:0] d;
      logic [15:0] c;
      d = refl_in ? mirror({8'h00, b}, 8) : {8'h00, b};
      c = crc ^ (d << 8);
      for (int i = 0; i < 8; i++) begin
        if (c[15]) begin
          c = (c << 1) ^ poly;
        end else begin
          c = c << 1;
        end
      end
      return c;
    endfunction

    function logic [15:0] seal(logic [15:0] c);
      return (refl_out ? mirror(c, 16) : c) ^ xorout;
    endfunction

    // Check value that a sender would put behind this payload under the current settings.
    function logic [15:0] frame_code(logic [7:0] pl [$]);
      logic [15:0] c;
      c = seed_val;
      foreach (pl[i]) c = crc_feed(c, pl[i]);
      return seal(c);
    endfunction

    function void layout(logic [7:0] k, output int unsigned plen, output int unsigned flen);
      case (k)
        KIND_SYNC: begin
          plen = SYNC_PAYLOAD;
          flen = SYNC_LEN;
        end
        KIND_SLEEP: begin
          plen = SLEEP_PAYLOAD;
          flen = SLEEP_LEN;
        end
        default: begin
          plen = 0;
          flen = 0;
        end
      endcase
    endfunction

    // Takes one accepted input beat and queues the result beats that it causes.
    function void take_byte(in_beat_t beat);
      int unsigned p;
      int unsigned plen;
      int unsigned flen;
      logic [7:0]  b;
      out_beat_t   verdict;
      b = beat.rx_byte;
      p = byte_count;
      layout(kind, plen, flen);
      if (p == 0) begin
        start_ok = (b == START_MARK);
        crc_run  = seed_val;
        crc_rx   = '0;
        end_ok   = 1'b0;
        kind     = '0;
      end else if (p == 1) begin
        kind = b;
      end else if (plen != 0) begin
        if (p < 2 + plen) begin
          payload[p-2] = b;
          crc_run      = crc_feed(crc_run, b);
        end else if (p < 4 + plen) begin
          crc_rx = {crc_rx[7:0], b};
        end else if (p == flen - 1) begin
          end_ok = (b == END_MARK);
        end
      end
      if (byte_count < count_cap) byte_count++;
      if (!beat.frame_end) return;

      layout(kind, plen, flen);
      verdict              = '0;
      verdict.status       = ST_REJECT;
      verdict.reject_cause = CAUSE_NONE;
      verdict.frame_kind   = kind;
      verdict.run_last     = 1'b1;
      // The checks are made in a fixed order, and the first failure wins. Only a frame
      // of a known type with a good start asks for a failure reply.
      if (!start_ok) begin
        verdict.reject_cause = CAUSE_BAD_START;
      end else if (plen == 0) begin
        verdict.reject_cause = CAUSE_BAD_TYPE;
      end else if (byte_count != flen) begin
        verdict.reject_cause = CAUSE_BAD_LENGTH;
        verdict.nack_due     = 1'b1;
      end else if (!end_ok) begin
        verdict.reject_cause = CAUSE_BAD_END;
        verdict.nack_due     = 1'b1;
      end else if (seal(crc_run) != crc_rx) begin
        verdict.reject_cause = CAUSE_CRC;
        verdict.nack_due     = 1'b1;
      end

      if (verdict.reject_cause == CAUSE_NONE) begin
        for (int i = 0; i < plen; i++) begin
          verdict.status        = (kind == KIND_SYNC) ? ST_SYNC : ST_SLEEP;
          verdict.payload_byte  = payload[i];
          verdict.payload_index = IDX_W'(i);
          verdict.run_last      = (i == plen - 1);
          awaited_beats.push_back(verdict);
        end
      end else begin
        awaited_beats.push_back(verdict);
      end
      clear_frame();
    endfunction

    function string show(out_beat_t b);
      return $sformatf("status=%0d cause=%0d nack=%0d kind=%02h byte=%02h idx=%0d last=%0d",
                       b.status, b.reject_cause, b.nack_due, b.frame_kind,
                       b.payload_byte, b.payload_index, b.run_last);
    endfunction

    function void note_fault(string msg);
      mismatches++;
      if (mismatches <= REPORT_CAP) $display("%0t: %s", $time, msg);
    endfunction

    // Compares one accepted result beat with the oldest expected beat.
    function void match_result(out_beat_t got);
      out_beat_t want;
      if (awaited_beats.size() == 0) begin
        note_fault($sformatf("result beat with none expected: %s", show(got)));
        return;
      end
      want = awaited_beats.pop_front();
      if (got.status !== want.status || got.reject_cause !== want.reject_cause ||
          got.nack_due !== want.nack_due || got.frame_kind !== want.frame_kind ||
          got.payload_byte !== want.payload_byte ||
          got.payload_index !== want.payload_index || got.run_last !== want.run_last) begin
        note_fault($sformatf("result mismatch\n  expected %s\n  actual   %s",
                             show(want), show(got)));
      end
    endfunction
  endclass

  // All inputs of the block start at known values.
  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = CFG_CRC_POLY;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_beat_t    in_beat   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_beat;

  // The chance of an idle burst is given in percent for each side, and the length of each
  // burst is random. sink_hold_req asks the receiver for one long hold-off, counted in
  // cycles by the receiver process itself.
  int          src_idle_pct  = 0;
  int          sink_idle_pct = 0;
  int          sink_hold_req = 0;
  int unsigned cycle_count   = 0;

  logic [7:0]           frame_bytes [$];
  frame_verdict_tracker tracker;

  framed_message_crc_checker #(.MAX_FRAME_BYTES(MAX_FRAME)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one byte at the falling edge and holds it until a rising edge with the stall
  // low. At that edge the byte counts as accepted and is given to the predictor.
  // Sometimes an idle burst follows. Otherwise valid stays high for the next beat.
  task automatic send_byte(logic [7:0] b, logic closing);
    in_beat_t beat;
    int       gap;
    beat.rx_byte   = b;
    beat.frame_end = closing;
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat  <= beat;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(beat);
    if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // The sender goes quiet until every expected beat has come out. Then it lets the
  // pipeline settle, so that the block is idle when this returns.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.awaited_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    tracker.set_reg(idx, v);
  endtask

  // Writes all five CRC registers in a row. The one-bit flags carry random upper
  // bits, which the block must ignore.
  task automatic load_setup(logic [15:0] poly, logic [15:0] seed, logic [15:0] xo,
                            logic rin, logic rout);
    write_reg(CFG_CRC_POLY, poly);
    write_reg(CFG_CRC_INIT, seed);
    write_reg(CFG_CRC_XOROUT, xo);
    write_reg(CFG_REFLECT_IN, {15'($urandom), rin});
    write_reg(CFG_REFLECT_OUT, {15'($urandom), rout});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Builds one frame in frame_bytes. A well-formed frame of a random known type
  // is made first, with its check value computed under the current settings.
  // Most shapes then break it in one place.
  function automatic void build_frame();
    logic [7:0]  pl [$];
    logic [7:0]  k;
    logic [15:0] code;
    int unsigned plen;
    int unsigned cut;
    int unsigned pick;
    frame_form_t shape;

    pick = $urandom_range(0, 99);
    if (pick < 52) shape = FORM_GOOD;
    else if (pick < 62) shape = FORM_BAD_CRC;
    else if (pick < 70) shape = FORM_BAD_END;
    else if (pick < 76) shape = FORM_BAD_START;
    else if (pick < 82) shape = FORM_BAD_TYPE;
    else if (pick < 89) shape = FORM_SHORT;
    else if (pick < 95) shape = FORM_LONG;
    else shape = FORM_NOISE;

    k    = $urandom_range(0, 1) ? KIND_SYNC : KIND_SLEEP;
    plen = (k == KIND_SYNC) ? SYNC_PAYLOAD : SLEEP_PAYLOAD;
    repeat (plen) pl.push_back(8'($urandom));
    code = tracker.frame_code(pl);

    frame_bytes.delete();
    frame_bytes.push_back(START_MARK);
    frame_bytes.push_back(k);
    foreach (pl[i]) frame_bytes.push_back(pl[i]);
    frame_bytes.push_back(code[15:8]);
    frame_bytes.push_back(code[7:0]);
    frame_bytes.push_back(END_MARK);

    case (shape)
      FORM_BAD_CRC: begin
        // One bit is flipped in the payload or in the check value. With a zero
        // polynomial a payload flip can still pass, and the predictor tracks that.
        cut = $urandom_range(2, plen + 3);
        frame_bytes[cut] = frame_bytes[cut] ^ 8'(1 << $urandom_range(0, 7));
      end
      FORM_BAD_END: begin
        frame_bytes[plen+4] = frame_bytes[plen+4] ^ 8'($urandom_range(1, 255));
      end
      FORM_BAD_START: begin
        frame_bytes[0] = frame_bytes[0] ^ 8'($urandom_range(1, 255));
      end
      FORM_BAD_TYPE: begin
        k = 8'($urandom);
        while (k == KIND_SYNC || k == KIND_SLEEP) k = 8'($urandom);
        frame_bytes[1] = k;
        cut = $urandom_range(2, frame_bytes.size());
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end
      FORM_SHORT: begin
        cut = $urandom_range(1, frame_bytes.size() - 1);
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end
      FORM_LONG: begin
        // Long frames of either type can run past the point where the byte count saturates.
        repeat ($urandom_range(1, 24)) frame_bytes.push_back(8'($urandom));
      end
      FORM_NOISE: begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 1)) frame_bytes[0] = START_MARK;
      end
      default: ;
    endcase
  endfunction

  task automatic run_frames(int unsigned budget);
    int unsigned sent;
    sent = 0;
    while (sent < budget) begin
      build_frame();
      sent += frame_bytes.size();
      send_frame();
    end
  endtask

  // Receiver pacing. out_stall changes only at falling edges. A long hold-off that
  // was asked for comes first. Otherwise stalled bursts of random length are
  // started at random.
  initial begin : sink_pacing
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (sink_hold_req > 0) begin
        hold_left     = sink_hold_req - 1;
        sink_hold_req = 0;
        out_stall <= 1'b1;
      end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        hold_left = $urandom_range(1, 14) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every result beat taken at a rising edge is checked against the predictor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.match_result(out_beat);
  end

  // Watchdog: a run that has not finished by now counts as a failure.
  initial begin : watchdog
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** framed_message_crc_checker: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  pl [$];
    logic [15:0] code;

    tracker = new(MAX_FRAME);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset settings. These are:
    // - a single bad start byte
    // - a lone start byte, which leaves the frame kind at zero
    // - an unknown type
    // - a known type that is cut short
    // - a good time sync frame whose payload holds the extreme byte values
    frame_bytes = '{8'hFF};
    send_frame();
    frame_bytes = '{START_MARK};
    send_frame();
    frame_bytes = '{START_MARK, 8'hFF};
    send_frame();
    frame_bytes = '{START_MARK, KIND_SLEEP};
    send_frame();
    pl   = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'h55, 8'hAA};
    code = tracker.frame_code(pl);
    frame_bytes = '{START_MARK, KIND_SYNC, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'h55,
                    8'hAA, code[15:8], code[7:0], END_MARK};
    send_frame();
    wait_drained();

    // All ones, with the output reflection switched off.
    load_setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    src_idle_pct  = 25;
    sink_idle_pct = 25;
    run_frames(55);
    wait_drained();

    // All zeros. The sender runs without gaps while the receiver stalls often.
    load_setup(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    src_idle_pct  = 0;
    sink_idle_pct = 40;
    run_frames(55);
    wait_drained();

    // An unreflected polynomial, with a gappy sender and a receiver that never stalls.
    load_setup(16'h1021, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
    src_idle_pct  = 40;
    sink_idle_pct = 0;
    run_frames(50);

    // The receiver holds off for a long stretch while frames keep coming back to
    // back. The pending verdict slot fills, and the block has to stall its input.
    // Afterwards the sender pauses until every expected beat has come out.
    sink_hold_req = 200;
    src_idle_pct  = 0;
    run_frames(50);
    wait_drained();

    load_setup(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
    src_idle_pct  = 15;
    sink_idle_pct = 15;
    run_frames(55);
    wait_drained();

    // The last part goes back to the reset settings, with no idling on either side.
    load_setup(CRC_POLY_RST, CRC_INIT_RST, CRC_XOROUT_RST, REFLECT_IN_RST, REFLECT_OUT_RST);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_frames(55);
    wait_drained();

    if (tracker.mismatches == 0 && tracker.awaited_beats.size() == 0) begin
      $display("** framed_message_crc_checker: PASSED **");
    end else begin
      $display("** framed_message_crc_checker: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/fmcc_pkg.sv
sv/framed_message_crc_checker.sv
bench/framed_message_crc_checker_tb.sv
